// File: src/tac_pkg.sv
package tac_pkg;

	localparam int OP_BITS      = 2;
	localparam int LETTER_BITS  = 5;
	localparam int MAX_LETTERS  = 10;
	localparam int WORD_BITS    = LETTER_BITS * MAX_LETTERS;
	localparam int LEN_BITS     = 4;
	localparam int FREQ_BITS    = 20;
	localparam int KEYS_BITS    = 4;
	localparam int LETTER_KINDS = 26;
	localparam int PAD_BITS     = LETTER_BITS * 12;

	localparam int NODE_COUNT_DEF = 4096;
	localparam int WORD_COUNT_DEF = 1024;

	typedef enum logic [OP_BITS-1:0] {
		OP_INSERT = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ISCAN,
		S_ISCANW,
		S_ICHECK,
		S_IRD,
		S_IRD2,
		S_ICMP,
		S_ILINK,
		S_IZERO,
		S_QSTEP,
		S_QSLOT,
		S_QCMP,
		S_QLINK,
		S_DONE
	} state_t;

	// Pick letter idx out of a packed word
	function automatic logic [LETTER_BITS-1:0] letter_at(
		input logic [WORD_BITS-1:0] w,
		input logic [LEN_BITS-1:0]  idx
	);
		logic [PAD_BITS-1:0] p;
		p = {{(PAD_BITS-WORD_BITS){1'b0}}, w};
		return p[int'(idx)*LETTER_BITS +: LETTER_BITS];
	endfunction

	// Order key: first letter most significant, letter+1 per place, zero past the end
	function automatic logic [WORD_BITS-1:0] sort_key(
		input logic [WORD_BITS-1:0] w,
		input logic [LEN_BITS-1:0]  len
	);
		logic [WORD_BITS-1:0] k;
		k = '0;
		for (int j = 0; j < MAX_LETTERS; j++) begin
			if (LEN_BITS'(j) < len) begin
				k[WORD_BITS-1-j*LETTER_BITS -: LETTER_BITS] =
					w[j*LETTER_BITS +: LETTER_BITS] + LETTER_BITS'(1);
			end
		end
		return k;
	endfunction

endpackage

// File: src/tac_req_if.sv
interface tac_req_if;
	logic                            valid;
	logic                            ready;
	logic [tac_pkg::OP_BITS-1:0]     operation;
	logic [tac_pkg::WORD_BITS-1:0]   word_letters;
	logic [tac_pkg::LEN_BITS-1:0]    word_length;
	logic [tac_pkg::FREQ_BITS-1:0]   frequency;

	modport source (output valid, operation, word_letters, word_length, frequency,
		input ready);
	modport sink (input valid, operation, word_letters, word_length, frequency,
		output ready);
endinterface

// File: src/tac_rsp_if.sv
interface tac_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tac_pkg::KEYS_BITS-1:0] keystrokes;
	logic                          table_full;

	modport source (output valid, keystrokes, table_full, input ready);
	modport sink (input valid, keystrokes, table_full, output ready);
endinterface

// File: src/trie_autocomplete_keystrokes.sv
// Channel | Dir | Payload                                           | Transfer
// req     | in  | operation, word_letters, word_length, frequency   | valid & ready
// rsp     | out | keystrokes, table_full                            | valid & ready
//
// One request at a time: ready only while the sequencer is idle.
// Query: per prefix, QSTEP, QSLOT, QCMP, QLINK (node info, word slot, link row reads).
// Insert: ISCAN/ISCANW size the path; IRD, IRD2, ICMP, ILINK per level, plus IZERO per new node.
// Each level of the walk reads the node info, link and word memories once.
// Reset clears the root links and the pool counters at once; no clearing pass.
// A finished result waits in the output register while the next request enters.
module trie_autocomplete_keystrokes #(
	parameter int NODE_COUNT = tac_pkg::NODE_COUNT_DEF,
	parameter int WORD_COUNT = tac_pkg::WORD_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tac_req_if.sink   req,
	tac_rsp_if.source rsp
);
	import tac_pkg::*;

	localparam int NW   = $clog2(NODE_COUNT);
	localparam int NCW  = $clog2(NODE_COUNT + 1);
	localparam int SW   = $clog2(WORD_COUNT);
	localparam int WCW  = $clog2(WORD_COUNT + 1);
	localparam int ROWW = LETTER_KINDS * NW;
	localparam int INFW = FREQ_BITS + SW;
	localparam int WMW  = LEN_BITS + WORD_BITS;

	state_t state_q, state_d;

	logic [NCW-1:0] nodes_q;
	logic [WCW-1:0] words_q;
	logic [NW-1:0]  root_q [LETTER_KINDS];
	logic           ov_q;

	op_t                  op_q;
	logic [WORD_BITS-1:0] w_q;
	logic [LEN_BITS-1:0]  len_q;
	logic [FREQ_BITS-1:0] freq_q;
	logic [NW-1:0]        node_q;
	logic [LEN_BITS-1:0]  i_q;
	logic [LEN_BITS-1:0]  need_q;
	logic [SW-1:0]        slot_q;
	logic [KEYS_BITS-1:0] rkeys_q, okeys_q;
	logic                 rfull_q, ofull_q;

	// Memories
	logic [ROWW-1:0] link_mem [NODE_COUNT];
	logic [INFW-1:0] info_mem [NODE_COUNT];
	logic [WMW-1:0]  word_mem [WORD_COUNT];
	logic [ROWW-1:0] link_rd_q;
	logic [INFW-1:0] info_rd_q;
	logic [WMW-1:0]  word_rd_q;

	logic            link_re, link_we, info_re, info_we, word_re, word_we;
	logic [NW-1:0]   link_ra, link_wa, info_ra, info_wa;
	logic [SW-1:0]   word_ra;
	logic [ROWW-1:0] link_wd;
	logic [INFW-1:0] info_wd;

	// Request decode
	logic                   acc;
	logic [LEN_BITS-1:0]    in_len;
	logic [WORD_BITS-1:0]   in_w;
	logic                   in_bad;
	logic [LETTER_BITS-1:0] in_l0;
	op_t                    in_op;

	// Step helpers
	logic [LETTER_BITS-1:0] l0, lcur, lnext;
	logic [NW-1:0]          root_hit, child, nodes_idx;
	logic [ROWW-1:0]        row_upd;
	logic [NCW:0]           node_sum;
	logic                   full_hit, take, match;
	logic [FREQ_BITS-1:0]   bf;
	logic [SW-1:0]          bs;
	logic [LEN_BITS-1:0]    i_inc;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign in_op     = op_t'(req.operation);

	// Saturate the length, mask unused letters, flag bad letter codes
	always_comb begin
		in_len = (req.word_length > LEN_BITS'(MAX_LETTERS)) ? LEN_BITS'(MAX_LETTERS)
			: req.word_length;
		in_w   = '0;
		in_bad = 1'b0;
		for (int j = 0; j < MAX_LETTERS; j++) begin
			if (LEN_BITS'(j) < in_len) begin
				in_w[j*LETTER_BITS +: LETTER_BITS] =
					req.word_letters[j*LETTER_BITS +: LETTER_BITS];
				if (req.word_letters[j*LETTER_BITS +: LETTER_BITS] >=
						LETTER_BITS'(LETTER_KINDS)) begin
					in_bad = 1'b1;
				end
			end
		end
		in_l0 = in_w[LETTER_BITS-1:0];
	end

	// Per-step values
	always_comb begin
		i_inc     = i_q + LEN_BITS'(1);
		l0        = letter_at(w_q, '0);
		lcur      = letter_at(w_q, i_q);
		lnext     = letter_at(w_q, i_inc);
		root_hit  = root_q[l0];
		nodes_idx = nodes_q[NW-1:0];
		child     = link_rd_q[int'(lnext)*NW +: NW];
		row_upd   = link_rd_q;
		row_upd[int'(lnext)*NW +: NW] = nodes_idx;
		node_sum  = (NCW+1)'(nodes_q) + (NCW+1)'(need_q);
		full_hit  = (words_q >= WCW'(WORD_COUNT)) ||
			(node_sum > (NCW+1)'(NODE_COUNT));
		bf        = info_rd_q[INFW-1 -: FREQ_BITS];
		bs        = info_rd_q[SW-1:0];
		take      = (bf < freq_q) || ((bf == freq_q) && ((bf == '0) ||
			(sort_key(w_q, len_q) <= sort_key(word_rd_q[WORD_BITS-1:0],
				word_rd_q[WMW-1 -: LEN_BITS]))));
		match     = (word_rd_q[WMW-1 -: LEN_BITS] == len_q) &&
			(word_rd_q[WORD_BITS-1:0] == w_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (in_op == OP_INSERT && in_len != '0 && !in_bad) begin
						state_d = S_ISCAN;
					end else if (in_op == OP_QUERY && in_len != '0) begin
						state_d = S_QSTEP;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_ISCAN: begin
				if (node_q == '0 || i_inc >= len_q) begin
					state_d = S_ICHECK;
				end else begin
					state_d = S_ISCANW;
				end
			end
			S_ISCANW: state_d = S_ISCAN;
			S_ICHECK: state_d = full_hit ? S_DONE : S_IRD;
			S_IRD:    state_d = S_IRD2;
			S_IRD2:   state_d = S_ICMP;
			S_ICMP:   state_d = (i_inc >= len_q) ? S_DONE : S_ILINK;
			S_ILINK:  state_d = (child == '0) ? S_IZERO : S_IRD;
			S_IZERO:  state_d = S_IRD;
			S_QSTEP: begin
				if (i_q >= len_q || node_q == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_QSLOT;
				end
			end
			S_QSLOT: state_d = S_QCMP;
			S_QCMP: begin
				if (match || lcur >= LETTER_BITS'(LETTER_KINDS)) begin
					state_d = match ? S_DONE : S_QSTEP;
				end else begin
					state_d = S_QLINK;
				end
			end
			S_QLINK: state_d = S_QSTEP;
			S_DONE: begin
				if (!ov_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory controls
	always_comb begin
		link_re = 1'b0;
		link_we = 1'b0;
		info_re = 1'b0;
		info_we = 1'b0;
		word_re = 1'b0;
		word_we = 1'b0;
		link_ra = node_q;
		link_wa = node_q;
		link_wd = '0;
		info_ra = node_q;
		info_wa = node_q;
		info_wd = '0;
		word_ra = bs;
		unique case (state_q)
			S_ISCAN: begin
				link_re = (node_q != '0) && (i_inc < len_q);
			end
			S_ICHECK: begin
				word_we = !full_hit;
				if (!full_hit && root_hit == '0) begin
					link_we = 1'b1;
					link_wa = nodes_idx;
					info_we = 1'b1;
					info_wa = nodes_idx;
				end
			end
			S_IRD:  info_re = 1'b1;
			S_IRD2: word_re = 1'b1;
			S_ICMP: begin
				info_we = take;
				info_wd = {freq_q, slot_q};
				link_re = (i_inc < len_q);
			end
			S_ILINK: begin
				if (child == '0) begin
					link_we = 1'b1;
					link_wd = row_upd;
					info_we = 1'b1;
					info_wa = nodes_idx;
				end
			end
			S_IZERO: link_we = 1'b1;
			S_QSTEP: info_re = (i_q < len_q) && (node_q != '0);
			S_QSLOT: word_re = 1'b1;
			S_QCMP:  link_re = !match && (lcur < LETTER_BITS'(LETTER_KINDS));
			default: begin
			end
		endcase
	end

	// Link rows, node info, stored words
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (link_re) begin
			link_rd_q <= link_mem[link_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (info_we) begin
			info_mem[info_wa] <= info_wd;
		end
		if (info_re) begin
			info_rd_q <= info_mem[info_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (word_we) begin
			word_mem[words_q[SW-1:0]] <= {len_q, w_q};
		end
		if (word_re) begin
			word_rd_q <= word_mem[word_ra];
		end
	end

	// Control state: sequencer, pool counters, root links, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nodes_q <= NCW'(1);
			words_q <= '0;
			ov_q    <= 1'b0;
			for (int j = 0; j < LETTER_KINDS; j++) begin
				root_q[j] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (rsp.valid && rsp.ready) begin
				ov_q <= 1'b0;
			end
			if (state_q == S_DONE && (!ov_q || rsp.ready)) begin
				ov_q <= 1'b1;
			end
			if (acc && in_op == OP_CLEAR) begin
				nodes_q <= NCW'(1);
				words_q <= '0;
				for (int j = 0; j < LETTER_KINDS; j++) begin
					root_q[j] <= '0;
				end
			end
			if (state_q == S_ICHECK && !full_hit) begin
				words_q <= words_q + WCW'(1);
				if (root_hit == '0) begin
					root_q[l0] <= nodes_idx;
					nodes_q    <= nodes_q + NCW'(1);
				end
			end
			if (state_q == S_ILINK && child == '0) begin
				nodes_q <= nodes_q + NCW'(1);
			end
		end
	end

	// Payload: request copy, walk position, result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					op_q    <= in_op;
					w_q     <= in_w;
					len_q   <= in_len;
					freq_q  <= req.frequency;
					rkeys_q <= '0;
					rfull_q <= 1'b0;
					if (in_op == OP_QUERY) begin
						node_q <= (in_l0 < LETTER_BITS'(LETTER_KINDS)) ? root_q[in_l0] : '0;
						i_q    <= LEN_BITS'(1);
					end else begin
						node_q <= root_q[in_l0];
						i_q    <= '0;
					end
				end
			end
			S_ISCAN: begin
				if (node_q == '0) begin
					need_q <= len_q - i_q;
				end else if (i_inc >= len_q) begin
					need_q <= '0;
				end
			end
			S_ISCANW: begin
				node_q <= child;
				i_q    <= i_inc;
			end
			S_ICHECK: begin
				rfull_q <= full_hit;
				slot_q  <= words_q[SW-1:0];
				node_q  <= (root_hit == '0) ? nodes_idx : root_hit;
				i_q     <= '0;
			end
			S_ILINK: begin
				if (child == '0) begin
					node_q <= nodes_idx;
				end else begin
					node_q <= child;
					i_q    <= i_inc;
				end
			end
			S_IZERO: i_q <= i_inc;
			S_QSTEP: begin
				if (i_q >= len_q || node_q == '0) begin
					rkeys_q <= KEYS_BITS'(len_q);
				end
			end
			S_QCMP: begin
				if (match) begin
					rkeys_q <= KEYS_BITS'(i_inc);
				end else if (lcur >= LETTER_BITS'(LETTER_KINDS)) begin
					node_q <= '0;
					i_q    <= i_inc;
				end
			end
			S_QLINK: begin
				node_q <= link_rd_q[int'(lcur)*NW +: NW];
				i_q    <= i_inc;
			end
			S_DONE: begin
				if (!ov_q || rsp.ready) begin
					okeys_q <= rkeys_q;
					ofull_q <= rfull_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid      = ov_q;
	assign rsp.keystrokes = okeys_q;
	assign rsp.table_full = ofull_q;

	// Checks
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req.ready)
		else $error("request taken while a previous one is in flight");

	a_pool_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(nodes_q != '0) && (nodes_q <= NCW'(NODE_COUNT)) &&
		(words_q <= WCW'(WORD_COUNT)))
		else $error("pool counters out of range");

	a_new_node_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IZERO) |-> ((NCW'(node_q) + NCW'(1)) == nodes_q))
		else $error("fresh node is not the last one allocated");

	a_query_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QSTEP) |-> (i_q != '0) && (op_q == OP_QUERY))
		else $error("query walk at prefix length zero");

	a_full_insert_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rfull_q) |-> (rkeys_q == '0) && (op_q == OP_INSERT))
		else $error("full flag on a non-insert result");

endmodule
